// File: hdl/ncr_pkg.sv
// Shared constants and types for the nearest-centroid reassignment block.
`default_nettype none

package ncr_pkg;

  // Default sizes of the centroid table and the coordinate format.
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_DIMS     = 16;
  localparam int DEF_COORD_WIDTH  = 16;

  // Fixed widths of the port fields.
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;
  localparam int CLUSTER_IDX_W = 4;
  localparam int DIM_IDX_W     = 4;
  localparam int IN_COORD_W    = 16;
  localparam int SWITCH_CNT_W  = 32;

  // Configuration register indexes and reset value.
  localparam logic [CFG_IDX_W-1:0]  REG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_NUM_DIMS     = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VAL    = 5'd16;

  // Input action codes.
  localparam logic ACT_CENTROID = 1'b0;
  localparam logic ACT_POINT    = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EVAL,
    ST_SELECT,
    ST_DONE
  } state_t;

  // Which distance the shared unit is accumulating.
  typedef enum logic [1:0] {
    PASS_CUR,   // current centroid to point
    PASS_DK,    // candidate centroid to point
    PASS_DKC    // candidate centroid to current centroid
  } pass_t;

endpackage

`default_nettype wire

// File: hdl/nearest_centroid_reassign.sv
// Top level of the nearest-centroid reassignment block.
`default_nettype none

// Centroid loads and point coordinates without the last-coordinate flag are
// accepted whenever the block is idle. The last coordinate of a point starts a
// decision run on one shared subtract, square and accumulate unit fed from a
// two-read-port centroid memory: one pass for the current centroid, then two
// passes for every other centroid in use, or no pass at all when the current
// cluster is out of range. The input is not ready during a run. The result sits
// in an output register, so a run may finish while the previous result still
// waits. Centroid and point entries that were never written read as unknown.
module nearest_centroid_reassign #(
  parameter int MAX_CLUSTERS = ncr_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_DIMS     = ncr_pkg::DEF_MAX_DIMS,
  parameter int COORD_WIDTH  = ncr_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Configuration write port.
  input  wire logic                                   cfg_we,
  input  wire logic [ncr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [ncr_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  // Input channel.
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_action,
  input  wire logic [ncr_pkg::CLUSTER_IDX_W-1:0]      in_cluster_index,
  input  wire logic [ncr_pkg::DIM_IDX_W-1:0]          in_dim_index,
  input  wire logic signed [ncr_pkg::IN_COORD_W-1:0]  in_coord_value,
  input  wire logic [ncr_pkg::CLUSTER_IDX_W-1:0]      in_current_cluster,
  input  wire logic                                   in_last_coord,
  // Result channel.
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [ncr_pkg::CLUSTER_IDX_W-1:0]           out_new_cluster,
  output logic                                        out_switched,
  output logic [ncr_pkg::SWITCH_CNT_W-1:0]            out_switch_count
);

  localparam int CL_AW   = $clog2(MAX_CLUSTERS);
  localparam int DIM_AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NC_W    = $clog2(MAX_CLUSTERS + 1);
  localparam int ND_W    = $clog2(MAX_DIMS + 1);
  localparam int MEM_AW  = CL_AW + DIM_AW;
  localparam int MEM_D   = MAX_CLUSTERS << DIM_AW;
  localparam int SQ_W    = 2 * COORD_WIDTH;
  localparam int SUM_RAW = SQ_W + $clog2(MAX_DIMS + 1);
  localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
  localparam int CIW     = ncr_pkg::CLUSTER_IDX_W;
  localparam int CNT_W   = ncr_pkg::SWITCH_CNT_W;

  // Configuration registers.
  logic [ncr_pkg::CFG_DATA_W-1:0] num_clusters_r;
  logic [ncr_pkg::CFG_DATA_W-1:0] num_dims_r;

  // Sequencer state.
  ncr_pkg::state_t state_r, state_nxt;
  ncr_pkg::pass_t  pass_r, pass_nxt;
  logic [DIM_AW-1:0] j_r, j_nxt;
  logic [NC_W-1:0]   k_r, k_nxt;
  logic [CIW-1:0]    cur_r, cur_nxt;
  logic [CIW-1:0]    best_r, best_nxt;
  logic              found_r, found_nxt;
  logic [SUM_W-1:0]  dcur_r, dcur_nxt;
  logic [SUM_W-1:0]  dk_r, dk_nxt;
  logic [SUM_W-1:0]  bestd_r, bestd_nxt;

  // Control strobes from the sequencer.
  logic issue;
  logic acc_clr;
  logic load_out;
  logic issue_last;

  // Clamped register values.
  logic [NC_W-1:0] nc_c;
  logic [ND_W-1:0] nd_c;

  // Storage.
  logic [COORD_WIDTH-1:0] centroid_mem [MEM_D];
  logic [COORD_WIDTH-1:0] point_buf [MAX_DIMS];
  logic [COORD_WIDTH-1:0] coord_w;

  // Shared unit pipeline.
  logic [MEM_AW-1:0]      addr_a;
  logic [MEM_AW-1:0]      addr_b;
  logic [CL_AW-1:0]       clus_a;
  logic [COORD_WIDTH-1:0] mem_a_q_r;
  logic [COORD_WIDTH-1:0] mem_b_q_r;
  logic [COORD_WIDTH-1:0] pt_q_r;
  logic                   s1_v_r, s2_v_r, s3_v_r;
  logic                   s1_usept_r;
  logic [COORD_WIDTH-1:0] op_b;
  logic signed [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH-1:0] mag_r;
  logic [SQ_W-1:0]        sq_r;
  logic [SUM_W:0]         sum_ext;
  logic [SUM_W-1:0]       acc_r;

  // Result registers.
  logic             out_valid_r;
  logic [CIW-1:0]   out_new_cluster_r;
  logic             out_switched_r;
  logic [CNT_W-1:0] out_switch_count_r;
  logic [CNT_W-1:0] total_r, total_nxt;

  logic in_fire;
  logic load_fire;
  logic point_fire;

  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (in_action == ncr_pkg::ACT_CENTROID) &&
                      (32'(in_cluster_index) < MAX_CLUSTERS) &&
                      (32'(in_dim_index) < MAX_DIMS);
  assign point_fire = in_fire && (in_action == ncr_pkg::ACT_POINT) &&
                      (32'(in_dim_index) < MAX_DIMS);

  // Stored coordinate: the Q8.8 input sign-extended or cut to the stored width.
  assign coord_w = COORD_WIDTH'(in_coord_value);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= ncr_pkg::CFG_RESET_VAL;
      num_dims_r     <= ncr_pkg::CFG_RESET_VAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ncr_pkg::REG_NUM_CLUSTERS: num_clusters_r <= cfg_wdata;
        ncr_pkg::REG_NUM_DIMS:     num_dims_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the register values to 1..MAX.
  always_comb begin
    if (num_clusters_r == '0) begin
      nc_c = NC_W'(1);
    end else if (32'(num_clusters_r) > MAX_CLUSTERS) begin
      nc_c = NC_W'(MAX_CLUSTERS);
    end else begin
      nc_c = NC_W'(num_clusters_r);
    end
    if (num_dims_r == '0) begin
      nd_c = ND_W'(1);
    end else if (32'(num_dims_r) > MAX_DIMS) begin
      nd_c = ND_W'(MAX_DIMS);
    end else begin
      nd_c = ND_W'(num_dims_r);
    end
  end

  // Centroid memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      centroid_mem[{CL_AW'(in_cluster_index), DIM_AW'(in_dim_index)}] <= coord_w;
    end
  end

  assign clus_a = (pass_r == ncr_pkg::PASS_CUR) ? CL_AW'(cur_r) : k_r[CL_AW-1:0];
  assign addr_a = {clus_a, j_r};
  assign addr_b = {CL_AW'(cur_r), j_r};

  always_ff @(posedge clk) begin
    if (issue) begin
      mem_a_q_r <= centroid_mem[addr_a];
      mem_b_q_r <= centroid_mem[addr_b];
      pt_q_r    <= point_buf[j_r];
    end
  end

  // Point buffer.
  always_ff @(posedge clk) begin
    if (point_fire) begin
      point_buf[DIM_AW'(in_dim_index)] <= coord_w;
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Stage 2: absolute difference of the two operands.
  assign op_b = s1_usept_r ? pt_q_r : mem_b_q_r;
  assign diff = $signed({mem_a_q_r[COORD_WIDTH-1], mem_a_q_r}) -
                $signed({op_b[COORD_WIDTH-1], op_b});

  always_ff @(posedge clk) begin
    s1_usept_r <= (pass_r != ncr_pkg::PASS_DKC);
    mag_r      <= diff[COORD_WIDTH] ? COORD_WIDTH'(-diff) : COORD_WIDTH'(diff);
    sq_r       <= SQ_W'(mag_r) * SQ_W'(mag_r);
  end

  // Stage 4: saturating accumulation of the squares.
  assign sum_ext = {1'b0, acc_r} + (SUM_W + 1)'(sq_r);

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc_r <= '0;
    end else if (s3_v_r) begin
      acc_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end
  end

  assign issue_last = (ND_W'(j_r) + ND_W'(1)) == nd_c;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncr_pkg::ST_IDLE;
      pass_r  <= ncr_pkg::PASS_CUR;
      j_r     <= '0;
      k_r     <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    best_r  <= best_nxt;
    dcur_r  <= dcur_nxt;
    dk_r    <= dk_nxt;
    bestd_r <= bestd_nxt;
  end

  // Next state and control strobes.
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    dcur_nxt  = dcur_r;
    dk_nxt    = dk_r;
    bestd_nxt = bestd_r;
    in_ready  = 1'b0;
    issue     = 1'b0;
    acc_clr   = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ncr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_action == ncr_pkg::ACT_POINT) && in_last_coord) begin
          cur_nxt   = in_current_cluster;
          best_nxt  = in_current_cluster;
          found_nxt = 1'b0;
          if (32'(in_current_cluster) >= 32'(nc_c)) begin
            state_nxt = ncr_pkg::ST_DONE;
          end else begin
            pass_nxt  = ncr_pkg::PASS_CUR;
            j_nxt     = '0;
            acc_clr   = 1'b1;
            state_nxt = ncr_pkg::ST_ISSUE;
          end
        end
      end
      ncr_pkg::ST_ISSUE: begin
        issue = 1'b1;
        if (issue_last) begin
          state_nxt = ncr_pkg::ST_DRAIN;
        end else begin
          j_nxt = j_r + DIM_AW'(1);
        end
      end
      ncr_pkg::ST_DRAIN: begin
        if (!(s1_v_r || s2_v_r || s3_v_r)) begin
          state_nxt = ncr_pkg::ST_EVAL;
        end
      end
      ncr_pkg::ST_EVAL: begin
        case (pass_r)
          ncr_pkg::PASS_CUR: begin
            dcur_nxt  = acc_r;
            k_nxt     = '0;
            state_nxt = ncr_pkg::ST_SELECT;
          end
          ncr_pkg::PASS_DK: begin
            dk_nxt    = acc_r;
            pass_nxt  = ncr_pkg::PASS_DKC;
            j_nxt     = '0;
            acc_clr   = 1'b1;
            state_nxt = ncr_pkg::ST_ISSUE;
          end
          default: begin
            // Candidate must beat the current centroid on both distances.
            if ((dk_r < dcur_r) && (acc_r < dcur_r) && (!found_r || (dk_r < bestd_r))) begin
              found_nxt = 1'b1;
              bestd_nxt = dk_r;
              best_nxt  = CIW'(k_r);
            end
            k_nxt     = k_r + NC_W'(1);
            state_nxt = ncr_pkg::ST_SELECT;
          end
        endcase
      end
      ncr_pkg::ST_SELECT: begin
        if (k_r >= nc_c) begin
          state_nxt = ncr_pkg::ST_DONE;
        end else if (k_r == NC_W'(cur_r)) begin
          k_nxt = k_r + NC_W'(1);
        end else begin
          pass_nxt  = ncr_pkg::PASS_DK;
          j_nxt     = '0;
          acc_clr   = 1'b1;
          state_nxt = ncr_pkg::ST_ISSUE;
        end
      end
      ncr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ncr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ncr_pkg::ST_IDLE;
      end
    endcase
  end

  // Saturating count of switched points.
  assign total_nxt = (found_r && (total_r != '1)) ? total_r + CNT_W'(1) : total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      total_r     <= total_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_new_cluster_r  <= best_r;
      out_switched_r     <= found_r;
      out_switch_count_r <= total_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_cluster  = out_new_cluster_r;
  assign out_switched     = out_switched_r;
  assign out_switch_count = out_switch_count_r;

endmodule

`default_nettype wire

// File: hdl/ncr_checker.sv
// Port-level checks for the nearest-centroid reassignment block, with its bind.
`default_nettype none

module ncr_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                in_action,
  input wire logic                                in_last_coord,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [ncr_pkg::CLUSTER_IDX_W-1:0]   out_new_cluster,
  input wire logic                                out_switched,
  input wire logic [ncr_pkg::SWITCH_CNT_W-1:0]    out_switch_count
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_cluster) &&
    $stable(out_switched) && $stable(out_switch_count))
    else $error("result changed while stalled");

  // A switched point is always counted.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_switch_count != '0)
    else $error("switch reported with zero count");

  // The running count never goes down from one result to the next.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_ready) && out_valid |->
    out_switch_count >= $past(out_switch_count))
    else $error("switch count decreased");

  // A final point coordinate starts a decision run, so the input goes busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ncr_pkg::ACT_POINT) && in_last_coord
    |=> !in_ready)
    else $error("input ready during a decision run");

endmodule

bind nearest_centroid_reassign ncr_checker u_ncr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_action        (in_action),
  .in_last_coord    (in_last_coord),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_new_cluster  (out_new_cluster),
  .out_switched     (out_switched),
  .out_switch_count (out_switch_count)
);

`default_nettype wire

// File: bench/ncr_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Transaction types and the assignment scoreboard for the nearest-centroid reassignment bench.

package ncr_scoreboard_pkg;
  import ncr_pkg::*;

  // One input transaction: a centroid load or a point coordinate.
  typedef struct packed {
    logic                            action;
    logic [CLUSTER_IDX_W-1:0]        cluster_index;
    logic [DIM_IDX_W-1:0]            dim_index;
    logic signed [IN_COORD_W-1:0]    coord_value;
    logic [CLUSTER_IDX_W-1:0]        current_cluster;
    logic                            last_coord;
  } coord_item_t;

  // One result transaction: the reassignment decision for a point.
  typedef struct packed {
    logic [CLUSTER_IDX_W-1:0] new_cluster;
    logic                     switched;
    logic [SWITCH_CNT_W-1:0]  switch_count;
  } assignment_t;

  class assignment_scoreboard;
    bit signed [IN_COORD_W-1:0] centroid_coord [DEF_MAX_CLUSTERS][DEF_MAX_DIMS];
    bit signed [IN_COORD_W-1:0] point_coord [DEF_MAX_DIMS];
    bit [SWITCH_CNT_W-1:0]      switch_total;
    bit [CFG_DATA_W-1:0]        clusters_reg;
    bit [CFG_DATA_W-1:0]        dims_reg;
    assignment_t                expected_assignments [$];
    int unsigned                mismatches;

    function new();
      switch_total = '0;
      clusters_reg = CFG_RESET_VAL;
      dims_reg     = CFG_RESET_VAL;
      mismatches   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_NUM_CLUSTERS: clusters_reg = value;
        REG_NUM_DIMS:     dims_reg = value;
        default: ;
      endcase
    endfunction

    // Zero counts as one, and the table size caps the register value.
    function int clamp_size(int value, int limit);
      if (value < 1) return 1;
      if (value > limit) return limit;
      return value;
    endfunction

    function int active_clusters();
      return clamp_size(clusters_reg, DEF_MAX_CLUSTERS);
    endfunction

    function int active_dims();
      return clamp_size(dims_reg, DEF_MAX_DIMS);
    endfunction

    // Squared distance from centroid k to the buffered point, or to centroid c when c >= 0.
    // At 16-bit coordinates and 16 dimensions the sum cannot saturate.
    function longint unsigned squared_distance(int k, int c, int n);
      longint unsigned sum;
      longint          a;
      longint          b;
      longint          diff;
      sum = 0;
      for (int j = 0; j < n; j++) begin
        a = centroid_coord[k][j];
        if (c < 0) b = point_coord[j];
        else b = centroid_coord[c][j];
        diff = a - b;
        if (diff < 0) diff = -diff;
        sum += longint'(diff) * longint'(diff);
      end
      return sum;
    endfunction

    // Apply one accepted input transaction and queue the decision it causes, if any.
    function void note_input(coord_item_t item);
      int              nc;
      int              nd;
      int              cur;
      longint unsigned d_cur;
      longint unsigned d_k;
      longint unsigned d_kc;
      longint unsigned d_best;
      bit              found;
      assignment_t     decision;
      if (item.action == ACT_CENTROID) begin
        centroid_coord[item.cluster_index][item.dim_index] = item.coord_value;
        return;
      end
      point_coord[item.dim_index] = item.coord_value;
      if (!item.last_coord) return;

      nc = active_clusters();
      nd = active_dims();
      cur = item.current_cluster;
      decision.new_cluster = item.current_cluster;
      found = 1'b0;
      d_best = 0;

      // A current cluster outside the active range never switches.
      if (cur < nc) begin
        d_cur = squared_distance(cur, -1, nd);
        for (int k = 0; k < nc; k++) begin
          if (k == cur) continue;
          d_k  = squared_distance(k, -1, nd);
          d_kc = squared_distance(k, cur, nd);
          // Strict compare keeps the lowest index on a tie.
          if (d_k < d_cur && d_kc < d_cur && (!found || d_k < d_best)) begin
            found = 1'b1;
            d_best = d_k;
            decision.new_cluster = CLUSTER_IDX_W'(k);
          end
        end
      end

      if (found && switch_total != '1) switch_total++;
      decision.switched = found;
      decision.switch_count = switch_total;
      expected_assignments.push_back(decision);
    endfunction

    // Compare one accepted result transaction with the oldest expected decision.
    function void check_result(assignment_t got);
      assignment_t want;
      if (expected_assignments.size() == 0) begin
        $error("Unexpected result: new_cluster %0d switched %0d switch_count %0d",
               got.new_cluster, got.switched, got.switch_count);
        mismatches++;
        return;
      end
      want = expected_assignments.pop_front();
      if (got.new_cluster !== want.new_cluster) begin
        $error("new_cluster: expected %0d, actual %0d", want.new_cluster, got.new_cluster);
        mismatches++;
      end
      if (got.switched !== want.switched) begin
        $error("switched: expected %0d, actual %0d", want.switched, got.switched);
        mismatches++;
      end
      if (got.switch_count !== want.switch_count) begin
        $error("switch_count: expected %0d, actual %0d", want.switch_count, got.switch_count);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: bench/tb_nearest_centroid_reassign.sv
`timescale 1ns / 1ps
// Top-level testbench for the nearest-centroid reassignment block.

module tb_nearest_centroid_reassign;
  import ncr_pkg::*;
  import ncr_scoreboard_pkg::*;

  localparam int     CLK_HALF_NS    = 6;
  localparam longint TIMEOUT_CYCLES = 10_000_000;
  localparam int     SETTLE_CYCLES  = 8;
  localparam int     END_CYCLES     = 800;
  localparam int     NUM_PHASES     = 9;
  // An index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_LIST = 2'd3;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_LONG_STALL} rx_pattern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_wdata = '0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_action = 1'b0;
  logic [CLUSTER_IDX_W-1:0]       in_cluster_index = '0;
  logic [DIM_IDX_W-1:0]           in_dim_index = '0;
  logic signed [IN_COORD_W-1:0]   in_coord_value = '0;
  logic [CLUSTER_IDX_W-1:0]       in_current_cluster = '0;
  logic                           in_last_coord = 1'b0;

  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [CLUSTER_IDX_W-1:0]       out_new_cluster;
  logic                           out_switched;
  logic [SWITCH_CNT_W-1:0]        out_switch_count;

  assignment_scoreboard sb;

  // Stimulus bookkeeping: which centroid entries hold data, and whether the
  // point buffer was filled for the present register setting.
  bit          centroid_loaded [DEF_MAX_CLUSTERS][DEF_MAX_DIMS];
  bit          point_whole;
  int unsigned items_sent = 0;
  int          burst_left = 0;

  // Phase settings: raw register values, including zero and out-of-range ones.
  int phase_clusters [NUM_PHASES] = '{1, 2, 4, 0, 6, 31, 8, 3, 16};
  int phase_dims     [NUM_PHASES] = '{1, 1, 3, 5, 2, 31, 4, 16, 2};
  int phase_items    [NUM_PHASES] = '{90, 110, 190, 60, 190, 290, 190, 160, 190};

  nearest_centroid_reassign dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_cluster_index   (in_cluster_index),
    .in_dim_index       (in_dim_index),
    .in_coord_value     (in_coord_value),
    .in_current_cluster (in_current_cluster),
    .in_last_coord      (in_last_coord),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_new_cluster    (out_new_cluster),
    .out_switched       (out_switched),
    .out_switch_count   (out_switch_count)
  );

  always begin
    #(CLK_HALF_NS) clk = 1'b1;
    #(CLK_HALF_NS) clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check each accepted transaction, and stall on a pattern that is
  // redrawn at random, periodically.
  int unsigned rx_cycle = 0;
  rx_pattern_t rx_mode = RX_ALWAYS;
  assignment_t observed;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      observed.new_cluster = out_new_cluster;
      observed.switched = out_switched;
      observed.switch_count = out_switch_count;
      sb.check_result(observed);
    end
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = rx_pattern_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:  out_ready <= 1'b1;
      RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:  out_ready <= (rx_cycle % 8 == 0);
      default:    out_ready <= (rx_cycle % 25 >= 20);
    endcase
  end

  function automatic coord_item_t make_item(logic action, int cidx, int didx, int value,
                                            int cur, logic last);
    coord_item_t item;
    item.action = action;
    item.cluster_index = CLUSTER_IDX_W'(cidx);
    item.dim_index = DIM_IDX_W'(didx);
    item.coord_value = IN_COORD_W'(value);
    item.current_cluster = CLUSTER_IDX_W'(cur);
    item.last_coord = last;
    return item;
  endfunction

  // Random coordinate around a center; a spread of zero means the full range.
  function automatic int rand_coord(int center, int spread);
    int v;
    if (spread == 0) return int'($urandom_range(0, 65535)) - 32768;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(0, 3))
      0:       return 'h40;
      1:       return 'h400;
      2:       return 'h4000;
      default: return 0;
    endcase
  endfunction

  // Present one input transaction and hold it until accepted. Valid stays high
  // across a burst; at the end of a burst the sender idles for a while.
  task automatic send_item(input coord_item_t item);
    in_valid <= 1'b1;
    in_action <= item.action;
    in_cluster_index <= item.cluster_index;
    in_dim_index <= item.dim_index;
    in_coord_value <= item.coord_value;
    in_current_cluster <= item.current_cluster;
    in_last_coord <= item.last_coord;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(item);
    items_sent++;
    if (item.action == ACT_CENTROID)
      centroid_loaded[item.cluster_index][item.dim_index] = 1'b1;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_register(index, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait until every expected decision has come back.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load the active part of the centroid table: every entry, or only the
  // entries never written, so that a decision never reads an empty entry.
  task automatic fill_centroids(input bit reload_all);
    int nc;
    int nd;
    int spread;
    nc = sb.active_clusters();
    nd = sb.active_dims();
    spread = pick_spread();
    for (int k = 0; k < nc; k++)
      for (int d = 0; d < nd; d++)
        if (reload_all || !centroid_loaded[k][d])
          send_item(make_item(ACT_CENTROID, k, d, rand_coord(0, spread),
                              $urandom_range(0, 15), 1'($urandom_range(0, 1))));
  endtask

  // A whole point near a random centroid, coordinates in shuffled order,
  // with the last-coordinate flag on the final one.
  task automatic send_point();
    int nc;
    int nd;
    int target;
    int cur;
    int spread;
    int j;
    int tmp;
    int order [DEF_MAX_DIMS];
    fill_centroids(1'b0);
    nc = sb.active_clusters();
    nd = sb.active_dims();
    target = $urandom_range(0, nc - 1);
    cur = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, nc - 1);
    spread = pick_spread();
    for (int i = 0; i < DEF_MAX_DIMS; i++) order[i] = i;
    for (int i = nd - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < nd; i++)
      send_item(make_item(ACT_POINT, $urandom_range(0, 15), order[i],
                          rand_coord(sb.centroid_coord[target][order[i]], spread),
                          (i == nd - 1) ? cur : $urandom_range(0, 15), i == nd - 1));
    point_whole = 1'b1;
  endtask

  initial begin
    int          r;
    int unsigned phase_end;
    sb = new();
    burst_left = $urandom_range(1, 12);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: three centroids in two dimensions, one at the extremes.
    write_reg(REG_NUM_CLUSTERS, 5'd3);
    write_reg(REG_NUM_DIMS, 5'd2);
    write_reg(REG_OUT_OF_LIST, 5'd31);
    send_item(make_item(ACT_CENTROID, 0, 0, 0, 0, 1'b0));
    send_item(make_item(ACT_CENTROID, 0, 1, 0, 0, 1'b0));
    send_item(make_item(ACT_CENTROID, 1, 0, 'h400, 0, 1'b0));
    send_item(make_item(ACT_CENTROID, 1, 1, 0, 0, 1'b0));
    send_item(make_item(ACT_CENTROID, 2, 0, -32768, 0, 1'b0));
    // A centroid load carrying the last-coordinate flag gives no result.
    send_item(make_item(ACT_CENTROID, 2, 1, 32767, 15, 1'b1));
    // Far past the neighbor: moves from cluster 0 to cluster 1.
    send_item(make_item(ACT_POINT, 0, 1, 0, 0, 1'b0));
    send_item(make_item(ACT_POINT, 0, 0, 'h500, 0, 1'b1));
    // Nearer to cluster 1, but the centroids are too far apart to switch.
    send_item(make_item(ACT_POINT, 0, 0, 'h380, 0, 1'b0));
    send_item(make_item(ACT_POINT, 0, 1, 0, 0, 1'b1));
    // Equal distance to clusters 0 and 1: the lower index wins.
    send_item(make_item(ACT_POINT, 15, 0, 'h200, 2, 1'b0));
    send_item(make_item(ACT_POINT, 15, 1, -'h7000, 2, 1'b1));
    // Coordinate extremes.
    send_item(make_item(ACT_POINT, 0, 0, 32767, 2, 1'b0));
    send_item(make_item(ACT_POINT, 0, 1, -32768, 2, 1'b1));
    // Current cluster out of range, far and at the boundary.
    send_item(make_item(ACT_POINT, 0, 0, 0, 15, 1'b0));
    send_item(make_item(ACT_POINT, 0, 1, 'h100, 15, 1'b1));
    send_item(make_item(ACT_POINT, 0, 1, 'h100, 3, 1'b1));
    // Point exactly on its own centroid stays put.
    send_item(make_item(ACT_POINT, 0, 0, 'h400, 1, 1'b0));
    send_item(make_item(ACT_POINT, 0, 1, 0, 1, 1'b1));
    wait_until_drained();

    // Random phases, each with its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_NUM_CLUSTERS, CFG_DATA_W'(phase_clusters[p]));
      write_reg(REG_NUM_DIMS, CFG_DATA_W'(phase_dims[p]));
      point_whole = 1'b0;
      fill_centroids(1'b1);
      phase_end = items_sent + phase_items[p];
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          send_point();
        end else if (r < 76 && point_whole) begin
          // Rewrite one coordinate of the buffered point and decide again.
          send_item(make_item(ACT_POINT, $urandom_range(0, 15),
                              $urandom_range(0, sb.active_dims() - 1),
                              rand_coord(0, pick_spread()), $urandom_range(0, 15), 1'b1));
        end else if (r < 84) begin
          // A broken point: some coordinates and no decision.
          repeat ($urandom_range(1, sb.active_dims()))
            send_item(make_item(ACT_POINT, $urandom_range(0, 15), $urandom_range(0, 15),
                                rand_coord(0, pick_spread()), $urandom_range(0, 15), 1'b0));
        end else if (r < 96) begin
          send_item(make_item(ACT_CENTROID, $urandom_range(0, 15), $urandom_range(0, 15),
                              rand_coord(0, pick_spread()), $urandom_range(0, 15),
                              1'($urandom_range(0, 1))));
        end else begin
          wait_until_drained();
        end
      end
      wait_until_drained();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_assignments.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
hdl/ncr_pkg.sv
hdl/nearest_centroid_reassign.sv
hdl/ncr_checker.sv
bench/ncr_scoreboard_pkg.sv
bench/tb_nearest_centroid_reassign.sv
